### src/necd_pkg.sv
// shared types and constants of the nec infrared frame decoder
package necd_pkg;

	localparam int CODE_BITS = 32;
	localparam int CNT_W     = $clog2(CODE_BITS);
	localparam int TICK_W    = 16;
	localparam int SHIFT_W   = 32;
	localparam int CFG_IDX_W = 4;

	localparam logic [CFG_IDX_W-1:0] REG_START_MARK_MIN  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_MARK_MAX  = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_START_SPACE_MIN = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_START_SPACE_MAX = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SHORT_MIN       = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SHORT_MAX       = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_SPACE_MIN  = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_SPACE_MAX  = 4'd7;

	localparam logic [TICK_W-1:0] RST_START_MARK_MIN  = 16'd47000;
	localparam logic [TICK_W-1:0] RST_START_MARK_MAX  = 16'd60825;
	localparam logic [TICK_W-1:0] RST_START_SPACE_MIN = 16'd22118;
	localparam logic [TICK_W-1:0] RST_START_SPACE_MAX = 16'd27648;
	localparam logic [TICK_W-1:0] RST_SHORT_MIN       = 16'd2212;
	localparam logic [TICK_W-1:0] RST_SHORT_MAX       = 16'd4424;
	localparam logic [TICK_W-1:0] RST_LONG_SPACE_MIN  = 16'd8294;
	localparam logic [TICK_W-1:0] RST_LONG_SPACE_MAX  = 16'd9953;

	localparam logic OP_EDGE     = 1'b0;
	localparam logic OP_OVERFLOW = 1'b1;

	typedef struct packed {
		logic [TICK_W-1:0] start_mark_min;
		logic [TICK_W-1:0] start_mark_max;
		logic [TICK_W-1:0] start_space_min;
		logic [TICK_W-1:0] start_space_max;
		logic [TICK_W-1:0] short_min;
		logic [TICK_W-1:0] short_max;
		logic [TICK_W-1:0] long_space_min;
		logic [TICK_W-1:0] long_space_max;
	} win_cfg_t;

	typedef struct packed {
		logic               opcode;
		logic [TICK_W-1:0]  interval;
	} event_t;

	typedef struct packed {
		logic               frame_valid;
		logic [SHIFT_W-1:0] frame_code;
		logic               both_edges;
	} result_t;

endpackage

### src/nec_ir_frame_decoder_unit.sv
// a request is captured in the input register, then its result is registered in the output register behind m_tvalid
// throughput: one event per cycle while m_tready stays high
// the input register refills while a result waits in the output register
// the state machine steps once per event as it moves from input to output register
// reset: arst_n clears the frame state, both pipeline valids and restores the default windows
module nec_ir_frame_decoder_unit
	import necd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [15:0]          s_tdata,   // interval
	input  logic                 s_tuser,   // opcode
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [39:0]          m_tdata,   // frame_code, both_edges, zero fill
	output logic                 m_tuser,   // frame_valid
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TICK_W-1:0]    cfg_data
);

	win_cfg_t cfg;
	event_t   ev_s1;
	result_t  res_c, res_s2;
	logic     valid_s1, valid_s2;
	logic     advance;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready  = !valid_s1 || advance;

	necd_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	necd_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.ev     (ev_s1),
		.cfg    (cfg),
		.res    (res_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			ev_s1.opcode   <= s_tuser;
			ev_s1.interval <= s_tdata;
		end
		if (advance) begin
			res_s2 <= res_c;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = res_s2.frame_valid;
	assign m_tdata  = {7'd0, res_s2.both_edges, res_s2.frame_code};

endmodule

### src/necd_regs.sv
// window configuration registers of the nec infrared frame decoder
module necd_regs
	import necd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [TICK_W-1:0]    wr_data,
	output win_cfg_t             cfg
);

	win_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_mark_min  <= RST_START_MARK_MIN;
			cfg_q.start_mark_max  <= RST_START_MARK_MAX;
			cfg_q.start_space_min <= RST_START_SPACE_MIN;
			cfg_q.start_space_max <= RST_START_SPACE_MAX;
			cfg_q.short_min       <= RST_SHORT_MIN;
			cfg_q.short_max       <= RST_SHORT_MAX;
			cfg_q.long_space_min  <= RST_LONG_SPACE_MIN;
			cfg_q.long_space_max  <= RST_LONG_SPACE_MAX;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_START_MARK_MIN:  cfg_q.start_mark_min  <= wr_data;
				REG_START_MARK_MAX:  cfg_q.start_mark_max  <= wr_data;
				REG_START_SPACE_MIN: cfg_q.start_space_min <= wr_data;
				REG_START_SPACE_MAX: cfg_q.start_space_max <= wr_data;
				REG_SHORT_MIN:       cfg_q.short_min       <= wr_data;
				REG_SHORT_MAX:       cfg_q.short_max       <= wr_data;
				REG_LONG_SPACE_MIN:  cfg_q.long_space_min  <= wr_data;
				REG_LONG_SPACE_MAX:  cfg_q.long_space_max  <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### src/necd_core.sv
// frame state machine and code shift register of the nec infrared frame decoder
module necd_core
	import necd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     step,
	input  event_t   ev,
	input  win_cfg_t cfg,
	output result_t  res
);

	localparam logic [2:0] PH_IDLE        = 3'd0;
	localparam logic [2:0] PH_START_MARK  = 3'd1;
	localparam logic [2:0] PH_START_SPACE = 3'd2;
	localparam logic [2:0] PH_BIT_MARK    = 3'd3;
	localparam logic [2:0] PH_BIT_SPACE   = 3'd4;
	localparam logic [2:0] PH_STOP_MARK   = 3'd5;

	logic [2:0]         phase_q, phase_d;
	logic [CNT_W-1:0]   bits_q, bits_d;
	logic [SHIFT_W-1:0] shift_q, shift_d;
	logic [CNT_W:0]     bits_inc;
	logic               in_start_mark, in_start_space, in_short, in_long;

	assign in_start_mark  = (ev.interval >= cfg.start_mark_min) &&
	                        (ev.interval <= cfg.start_mark_max);
	assign in_start_space = (ev.interval >= cfg.start_space_min) &&
	                        (ev.interval <= cfg.start_space_max);
	assign in_short       = (ev.interval >= cfg.short_min) &&
	                        (ev.interval <= cfg.short_max);
	assign in_long        = (ev.interval >= cfg.long_space_min) &&
	                        (ev.interval <= cfg.long_space_max);
	assign bits_inc       = {1'b0, bits_q} + {{CNT_W{1'b0}}, 1'b1};

	always_comb begin
		phase_d         = phase_q;
		bits_d          = bits_q;
		shift_d         = shift_q;
		res.frame_valid = 1'b0;
		res.frame_code  = '0;
		if (ev.opcode == OP_OVERFLOW) begin
			phase_d = PH_IDLE;
		end else begin
			unique case (phase_q)
				PH_IDLE: begin
					phase_d = PH_START_MARK;
				end
				PH_START_MARK: begin
					phase_d = in_start_mark ? PH_START_SPACE : PH_IDLE;
				end
				PH_START_SPACE: begin
					if (in_start_space) begin
						bits_d  = '0;
						shift_d = '0;
						phase_d = PH_BIT_MARK;
					end else begin
						phase_d = PH_IDLE;
					end
				end
				PH_BIT_MARK: begin
					phase_d = in_short ? PH_BIT_SPACE : PH_IDLE;
				end
				PH_BIT_SPACE: begin
					if (in_short || in_long) begin
						// short window wins when both match
						shift_d = {shift_q[SHIFT_W-2:0], !in_short};
						if (bits_inc >= (CNT_W+1)'(CODE_BITS)) begin
							bits_d  = '0;
							phase_d = PH_STOP_MARK;
						end else begin
							bits_d  = bits_inc[CNT_W-1:0];
							phase_d = PH_BIT_MARK;
						end
					end else begin
						phase_d = PH_IDLE;
					end
				end
				PH_STOP_MARK: begin
					if (in_short) begin
						res.frame_valid = 1'b1;
						res.frame_code  = shift_q;
					end
					phase_d = PH_IDLE;
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end
		res.both_edges = (phase_d != PH_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			bits_q  <= '0;
			shift_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			bits_q  <= bits_d;
			shift_q <= shift_d;
		end
	end

endmodule
